### rtl/ncwa_pkg.sv
package ncwa_pkg;

   localparam int CLUSTERS  = 1024;
   localparam int CLUSTER_W = $clog2(CLUSTERS);
   localparam int COUNT_W   = $clog2(CLUSTERS + 1);
   localparam int WEIGHT_W  = 16;
   localparam int SUM_W     = 32;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_EDGE  = 1'b1;

   // request tdata: cluster_id, edge_weight, zero fill to whole bytes
   localparam int REQ_BITS   = CLUSTER_W + WEIGHT_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   // response tdata: result_cluster, total_weight, slot_index, is_new, neighbor_count
   localparam int RSP_BITS   = CLUSTER_W + SUM_W + CLUSTER_W + 1 + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EDGE  = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_BFIN  = 5'b10000
   } state_type;

   // one entry of the cluster memory
   typedef struct packed {
      logic                 present;
      logic [CLUSTER_W-1:0] slot;
      logic [SUM_W-1:0]     weight;
   } entry_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0] cluster;
      logic [SUM_W-1:0]     total;
      logic [CLUSTER_W-1:0] slot;
      logic                 is_new;
      logic [COUNT_W-1:0]   count;
   } result_type;

endpackage

### rtl/neighbor_cluster_weight_accumulator.sv
// Sums edge weights from one graph node to each neighboring cluster. Each item
// (tuser 0 = begin node, 1 = edge) returns exactly one result item. The state
// sits in a 1024-entry cluster memory (present flag, touched-list slot, sum)
// and a 1024-entry touched-list memory, both with registered reads. An edge
// item does one read of the cluster memory, then the saturating add and
// write-back. A begin item walks the touched list one entry a cycle to clear
// the clusters that the previous node touched, then returns its result.
// After reset a clearing pass writes all 1024 cluster entries, one a cycle;
// no item is accepted until that pass is done. A result waits in an output
// register, so a new item can be taken while the last result is still
// unread.
module neighbor_cluster_weight_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] cluster_id, [25:10] edge_weight, [31:26] zero
   input  logic [ncwa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [9:0] result_cluster, [41:10] total_weight, [51:42] slot_index,
   // [52] is_new, [63:53] neighbor_count
   output logic [ncwa_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CW = ncwa_pkg::CLUSTER_W;
   localparam int NW = ncwa_pkg::COUNT_W;
   localparam int SW = ncwa_pkg::SUM_W;
   localparam int WW = ncwa_pkg::WEIGHT_W;

   ncwa_pkg::entry_type  cmem [ncwa_pkg::CLUSTERS];
   logic [CW-1:0]        tmem [ncwa_pkg::CLUSTERS];

   ncwa_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        clr_idx_ff, clr_idx_in;
   logic [NW-1:0]        walk_idx_ff, walk_idx_in;
   logic                 walk_pend_ff;
   logic [NW-1:0]        count_ff, count_in;
   logic [CW-1:0]        cl_ff;
   logic [WW-1:0]        wt_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   ncwa_pkg::result_type rsp_ff, rsp_in;

   ncwa_pkg::entry_type  c_rdata_ff;
   logic [CW-1:0]        t_rdata_ff;

   logic                 c_rd_en;
   logic [CW-1:0]        c_rd_addr;
   logic                 c_wr_en;
   logic [CW-1:0]        c_wr_addr;
   ncwa_pkg::entry_type  c_wr_data;
   logic                 t_rd_en;
   logic                 t_wr_en;
   logic [CW-1:0]        t_wr_addr;
   logic                 accept;
   logic                 out_free;
   logic [SW:0]          sum_wide;
   logic [SW-1:0]        sum_sat;

   assign req_tready = (state_ff == ncwa_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ncwa_pkg::RSP_DATA_W'({rsp_ff.count, rsp_ff.is_new, rsp_ff.slot,
                                              rsp_ff.total, rsp_ff.cluster});

   assign sum_wide = {1'b0, c_rdata_ff.weight} + {{(SW + 1 - WW){1'b0}}, wt_ff};
   assign sum_sat  = sum_wide[SW] ? ncwa_pkg::SUM_MAX : sum_wide[SW-1:0];

   assign c_rd_en   = accept && (req_tuser == ncwa_pkg::OP_EDGE);
   assign c_rd_addr = req_tdata[CW-1:0];
   assign t_rd_en   = (state_ff == ncwa_pkg::ST_WALK) && (walk_idx_ff != count_ff);

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      walk_idx_in  = walk_idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      c_wr_en      = 1'b0;
      c_wr_addr    = cl_ff;
      c_wr_data    = '0;
      t_wr_en      = 1'b0;
      t_wr_addr    = '0;

      // clearing walk: the touched-list read issued last cycle lands now
      if (walk_pend_ff) begin
         c_wr_en   = 1'b1;
         c_wr_addr = t_rdata_ff;
      end

      case (state_ff)
         ncwa_pkg::ST_CLEAR: begin
            c_wr_en    = 1'b1;
            c_wr_addr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == CW'(ncwa_pkg::CLUSTERS - 1)) begin
               state_in = ncwa_pkg::ST_IDLE;
            end
         end
         ncwa_pkg::ST_IDLE: begin
            if (accept) begin
               walk_idx_in = '0;
               state_in    = (req_tuser == ncwa_pkg::OP_EDGE) ? ncwa_pkg::ST_EDGE
                                                               : ncwa_pkg::ST_WALK;
            end
         end
         ncwa_pkg::ST_EDGE: begin
            if (out_free) begin
               c_wr_en           = 1'b1;
               c_wr_addr         = cl_ff;
               c_wr_data.present = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_in.cluster    = cl_ff;
               if (c_rdata_ff.present) begin
                  c_wr_data.slot   = c_rdata_ff.slot;
                  c_wr_data.weight = sum_sat;
                  rsp_in.is_new    = 1'b0;
                  rsp_in.count     = count_ff;
               end else begin
                  // first touch: append to the touched list
                  c_wr_data.slot   = count_ff[CW-1:0];
                  c_wr_data.weight = {{(SW - WW){1'b0}}, wt_ff};
                  t_wr_en          = 1'b1;
                  t_wr_addr        = count_ff[CW-1:0];
                  count_in         = count_ff + 1'b1;
                  rsp_in.is_new    = 1'b1;
                  rsp_in.count     = count_ff + 1'b1;
               end
               rsp_in.slot  = c_wr_data.slot;
               rsp_in.total = c_wr_data.weight;
               state_in     = ncwa_pkg::ST_IDLE;
            end
         end
         ncwa_pkg::ST_WALK: begin
            if (t_rd_en) begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end else begin
               state_in = ncwa_pkg::ST_BFIN;
            end
         end
         ncwa_pkg::ST_BFIN: begin
            if (out_free) begin
               c_wr_en           = 1'b1;
               c_wr_addr         = cl_ff;
               c_wr_data.present = 1'b1;
               t_wr_en           = 1'b1;
               t_wr_addr         = '0;
               count_in          = NW'(1);
               rsp_valid_in      = 1'b1;
               rsp_in.cluster    = cl_ff;
               rsp_in.total      = '0;
               rsp_in.slot       = '0;
               rsp_in.is_new     = 1'b1;
               rsp_in.count      = NW'(1);
               state_in          = ncwa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ncwa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncwa_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         walk_idx_ff  <= '0;
         walk_pend_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         walk_idx_ff  <= walk_idx_in;
         walk_pend_ff <= t_rd_en;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         cl_ff <= req_tdata[CW-1:0];
         wt_ff <= req_tdata[CW+WW-1:CW];
      end
   end

   always_ff @(posedge clock) begin
      if (c_wr_en) begin
         cmem[c_wr_addr] <= c_wr_data;
      end
      if (c_rd_en) begin
         c_rdata_ff <= cmem[c_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (t_wr_en) begin
         tmem[t_wr_addr] <= cl_ff;
      end
      if (t_rd_en) begin
         t_rdata_ff <= tmem[walk_idx_ff[CW-1:0]];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(ncwa_pkg::CLUSTERS))
      else $error("touched count beyond cluster range");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ncwa_pkg::ST_CLEAR) |-> !req_tready)
      else $error("item taken during clearing pass");

   a_edge_to_rmw: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == ncwa_pkg::OP_EDGE) |=> (state_ff == ncwa_pkg::ST_EDGE))
      else $error("edge item did not enter read-modify-write");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ncwa_pkg::ST_WALK) |-> (walk_idx_ff <= count_ff))
      else $error("clearing walk ran past touched count");

   a_begin_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ncwa_pkg::ST_BFIN && out_free)
         |=> (rsp_tvalid && rsp_ff.is_new && rsp_ff.count == NW'(1)))
      else $error("begin item result malformed");

endmodule
